>>> hw/rtl/afct_pkg.sv
// Shared constants and codes of the AM/FM/CW tone generator.
package afct_pkg;

  localparam int PHASE_BITS_DEF       = 32;
  localparam int TABLE_ADDR_BITS_DEF  = 10;
  localparam int SAMPLE_FRAC_BITS_DEF = 15;

  // signed Q1.15 cosine, AM envelope and gain widths
  localparam int COS_W  = 17;
  localparam int ENV_W  = 18;
  localparam int GAIN_W = 19;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 31;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int IDX_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // 1.0 in Q1.15
  localparam int UNITY = 32768;
  // round(2^32 / (2*pi)), 30 bits
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

  localparam logic [1:0] MODE_AM = 2'd0;
  localparam logic [1:0] MODE_FM = 2'd1;
  localparam logic [1:0] MODE_CW = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAR_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_IDX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AMPL      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_DEV  = 3'd6;

endpackage

>>> hw/rtl/afct_cos_rom.sv
// Quarter-wave cosine table with quadrant folding and registered read.
module afct_cos_rom #(
  parameter int PHASE_BITS      = afct_pkg::PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = afct_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rd_en,
  input  logic [PHASE_BITS-1:0]             phase,
  output logic signed [afct_pkg::COS_W-1:0] cos_q
);
  import afct_pkg::*;

  localparam int QUARTER = 1 << (TABLE_ADDR_BITS - 2);
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Q30 Taylor series of cos((pi/2)*k/QUARTER), rounded to unsigned Q1.15
  function automatic logic [15:0] cos_entry(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x    = (64'(k) * HALF_PI_Q30) >> (TABLE_ADDR_BITS - 2);
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = $signed(term);
    term = ((term * x2) >> 30) / 64'd2;   sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd12;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd30;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd56;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd90;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd132; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd182; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd240; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd306; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd380; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd462; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd552; sum = sum + $signed(term);
    if (sum < 0) sum = 0;
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 64'sd32768) sum = 64'sd32768;
    return sum[15:0];
  endfunction

  logic [15:0] tbl [QUARTER+1];

  genvar gk;
  for (gk = 0; gk <= QUARTER; gk++) begin : g_tbl
    assign tbl[gk] = cos_entry(gk);
  end

  logic [TABLE_ADDR_BITS-1:0] addr;
  logic [1:0]                 quad;
  logic [TABLE_ADDR_BITS-2:0] off;
  logic [TABLE_ADDR_BITS-2:0] idx;
  logic [15:0]                rd_r;
  logic                       neg_r;

  assign addr = phase[PHASE_BITS-1 -: TABLE_ADDR_BITS];
  assign quad = addr[TABLE_ADDR_BITS-1 -: 2];
  assign off  = {1'b0, addr[TABLE_ADDR_BITS-3:0]};
  // mirror the offset in the second and fourth quadrants
  assign idx  = quad[0] ? ((TABLE_ADDR_BITS-1)'(QUARTER) - off) : off;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r  <= tbl[idx];
      neg_r <= quad[1] ^ quad[0];
    end
  end

  assign cos_q = neg_r ? -$signed({1'b0, rd_r}) : $signed({1'b0, rd_r});

endmodule

>>> hw/rtl/afct_mul.sv
// Shared signed multiplier with registered product.
module afct_mul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [afct_pkg::MUL_A_W-1:0] a,
  input  logic signed [afct_pkg::MUL_B_W-1:0] b,
  output logic signed [afct_pkg::PROD_W-1:0]  prod_r
);
  import afct_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule

>>> hw/rtl/am_fm_cw_tone_generator.sv
// AM/FM/CW tone generator top level: registers, accumulators and sequencer.
//
// Each request on the input stream makes one sample of a DDS test record from
// a carrier and a baseband phase accumulator and a quarter-wave cosine table.
// Mode AM gives amplitude*(1+modulation_index*cos(base))*cos(carrier), FM gives
// cos(carrier + peak_deviation*sin(base)), CW (and the unused code) gives
// cos(base). AM and FM records run over indices 1..sample_count, CW over
// 0..sample_count-1; restart in bit 0 of in_tdata starts a new record with this
// sample, and out_tlast marks the final sample. The sequencer steps every
// product through a single shared multiplier and both lookups through one
// registered table port; the input is ready again once the result has been
// moved to the output register, so a new request is taken only after the
// last sample has left the sequencer, and a stalled output holds it back.
// Configuration is written through the cfg_ port; the user must write it only
// while no sample is in flight, as the block itself does not enforce this.
module am_fm_cw_tone_generator #(
  parameter int  PHASE_BITS       = afct_pkg::PHASE_BITS_DEF,
  parameter int  TABLE_ADDR_BITS  = afct_pkg::TABLE_ADDR_BITS_DEF,
  parameter int  SAMPLE_FRAC_BITS = afct_pkg::SAMPLE_FRAC_BITS_DEF,
  localparam int OUT_DATA_W = ((SAMPLE_FRAC_BITS + 2 + afct_pkg::IDX_W + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [afct_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [afct_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [0] restart
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [OUT_DATA_W-1:0]               out_tdata,  // sample, sample_index
  output logic                                out_tlast
);
  import afct_pkg::*;

  localparam int SW     = SAMPLE_FRAC_BITS + 2;
  localparam int OFF_SH = 59 - PHASE_BITS;
  localparam int FIN_SH = 30 - SAMPLE_FRAC_BITS;
  localparam logic [PHASE_BITS-1:0] QTR_PH = {2'b01, {(PHASE_BITS-2){1'b0}}};
  localparam logic signed [PROD_W-1:0] SAT_HI = {{(PROD_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] SAT_LO = {{(PROD_W-SW+1){1'b1}}, {(SW-1){1'b0}}};

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_LK1  = 11'b00000000010,
    S_MUL1 = 11'b00000000100,
    S_ENV  = 11'b00000001000,
    S_AMP  = 11'b00000010000,
    S_GAIN = 11'b00000100000,
    S_RAD  = 11'b00001000000,
    S_OFF  = 11'b00010000000,
    S_LK2  = 11'b00100000000,
    S_FMUL = 11'b01000000000,
    S_FIN  = 11'b10000000000
  } state_t;

  // floor((v + 2^(s-1)) / 2^s)
  function automatic logic signed [PROD_W-1:0] round_sh(
    input logic signed [PROD_W-1:0] v,
    input int unsigned              s
  );
    logic signed [PROD_W-1:0] h;
    h       = '0;
    h[s-1]  = 1'b1;
    return (v + h) >>> s;
  endfunction

  // configuration registers
  logic [1:0]        mode_r;
  logic [31:0]       car_step_r;
  logic [31:0]       base_step_r;
  logic [IDX_W-1:0]  count_r;
  logic [15:0]       mod_idx_r;
  logic [15:0]       ampl_r;
  logic [15:0]       freq_dev_r;

  // record state
  logic [PHASE_BITS-1:0] car_acc_r;
  logic [PHASE_BITS-1:0] base_acc_r;
  logic [IDX_W-1:0]      cnt_r;

  // per-sample working registers
  state_t                    state_r, state_nxt;
  logic [PHASE_BITS-1:0]     cph_r;
  logic [PHASE_BITS-1:0]     bph_r;
  logic signed [ENV_W-1:0]   env_r;
  logic signed [GAIN_W-1:0]  gain_r;
  logic [IDX_W-1:0]          idx_r;
  logic                      last_r;

  logic                      out_valid_r;
  logic signed [SW-1:0]      out_sample_r;
  logic [IDX_W-1:0]          out_index_r;
  logic                      out_last_r;

  logic                      in_acc;
  logic                      restart;
  logic                      start_w;
  logic [PHASE_BITS-1:0]     cstep;
  logic [PHASE_BITS-1:0]     bstep;
  logic [PHASE_BITS-1:0]     base_c;
  logic [PHASE_BITS-1:0]     base_b;
  logic [IDX_W-1:0]          cnt_base;
  logic [IDX_W:0]            cnt_p1;
  logic                      is_last_w;

  logic                      rom_en;
  logic [PHASE_BITS-1:0]     rom_phase;
  logic signed [COS_W-1:0]   rom_q;
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic signed [PROD_W-1:0]  env_full;
  logic signed [PROD_W-1:0]  gain_full;
  logic signed [PROD_W-1:0]  off_full;
  logic signed [PROD_W-1:0]  fin_full;
  logic signed [PROD_W-1:0]  fin_sat;
  logic                      out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign restart    = in_tdata[0];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_index_r, out_sample_r});
  assign out_tlast  = out_last_r;
  assign out_free   = !out_valid_r || out_tready;

  // record bookkeeping at acceptance
  assign start_w   = (mode_r == MODE_AM) || (mode_r == MODE_FM);
  assign cstep     = PHASE_BITS'(car_step_r);
  assign bstep     = PHASE_BITS'(base_step_r);
  assign base_c    = restart ? '0 : car_acc_r;
  assign base_b    = restart ? '0 : base_acc_r;
  assign cnt_base  = restart ? '0 : cnt_r;
  assign cnt_p1    = {1'b0, cnt_base} + (IDX_W+1)'(1);
  assign is_last_w = cnt_p1 >= {1'b0, count_r};

  assign env_full  = round_sh(prod, 15) + PROD_W'(UNITY);
  assign gain_full = round_sh(prod, 15);
  assign off_full  = round_sh(prod, OFF_SH);
  assign fin_full  = round_sh(prod, FIN_SH);

  always_comb begin
    if (fin_full > SAT_HI) begin
      fin_sat = SAT_HI;
    end else if (fin_full < SAT_LO) begin
      fin_sat = SAT_LO;
    end else begin
      fin_sat = fin_full;
    end
  end

  // table port: baseband first (shifted a quarter cycle for sine), carrier second
  always_comb begin
    rom_en    = (state_r == S_LK1) || (state_r == S_LK2);
    rom_phase = cph_r;
    if (state_r == S_LK1) begin
      rom_phase = (mode_r == MODE_FM) ? (bph_r - QTR_PH) : bph_r;
    end
  end

  // multiplier operand selection
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_r)
      S_MUL1: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(rom_q);
        case (mode_r)
          MODE_AM: mul_b = MUL_B_W'({1'b0, mod_idx_r});
          MODE_FM: mul_b = MUL_B_W'({1'b0, freq_dev_r});
          default: mul_b = MUL_B_W'(UNITY);
        endcase
      end
      S_AMP: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(env_r);
        mul_b  = MUL_B_W'({1'b0, ampl_r});
      end
      S_RAD: begin
        mul_en = 1'b1;
        mul_a  = $signed(prod[MUL_A_W-1:0]);
        mul_b  = MUL_B_W'({1'b0, INV_TWO_PI_Q32});
      end
      S_FMUL: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(rom_q);
        mul_b  = MUL_B_W'(gain_r);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_LK1;
      S_LK1:  state_nxt = S_MUL1;
      S_MUL1: begin
        case (mode_r)
          MODE_AM: state_nxt = S_ENV;
          MODE_FM: state_nxt = S_RAD;
          default: state_nxt = S_FIN;
        endcase
      end
      S_ENV:  state_nxt = S_AMP;
      S_AMP:  state_nxt = S_GAIN;
      S_GAIN: state_nxt = S_LK2;
      S_RAD:  state_nxt = S_OFF;
      S_OFF:  state_nxt = S_LK2;
      S_LK2:  state_nxt = S_FMUL;
      S_FMUL: state_nxt = S_FIN;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_AM;
      car_step_r  <= '0;
      base_step_r <= '0;
      count_r     <= IDX_W'(1024);
      mod_idx_r   <= 16'd16384;
      ampl_r      <= 16'd32768;
      freq_dev_r  <= 16'd4096;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:      mode_r      <= cfg_wdata[1:0];
        REG_CAR_STEP:  car_step_r  <= cfg_wdata;
        REG_BASE_STEP: base_step_r <= cfg_wdata;
        REG_COUNT:     count_r     <= cfg_wdata[IDX_W-1:0];
        REG_MOD_IDX:   mod_idx_r   <= cfg_wdata[15:0];
        REG_AMPL:      ampl_r      <= cfg_wdata[15:0];
        REG_FREQ_DEV:  freq_dev_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      car_acc_r   <= '0;
      base_acc_r  <= '0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        // advance the record, or drop back to its start after the last sample
        if (is_last_w) begin
          car_acc_r  <= '0;
          base_acc_r <= '0;
          cnt_r      <= '0;
        end else begin
          car_acc_r  <= base_c + cstep;
          base_acc_r <= base_b + bstep;
          cnt_r      <= cnt_p1[IDX_W-1:0];
        end
      end
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cph_r  <= start_w ? (base_c + cstep) : base_c;
      bph_r  <= start_w ? (base_b + bstep) : base_b;
      idx_r  <= cnt_base + IDX_W'(start_w);
      last_r <= is_last_w;
    end
    if (state_r == S_ENV) begin
      env_r <= ENV_W'(env_full);
    end
    if (state_r == S_GAIN) begin
      gain_r <= GAIN_W'(gain_full);
    end
    if (state_r == S_OFF) begin
      cph_r  <= cph_r + off_full[PHASE_BITS-1:0];
      gain_r <= GAIN_W'(UNITY);
    end
    if (state_r == S_FIN && out_free) begin
      out_sample_r <= SW'(fin_sat);
      out_index_r  <= idx_r;
      out_last_r   <= last_r;
    end
  end

  afct_cos_rom #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_cos_rom (
    .clk   (clk),
    .rd_en (rom_en),
    .phase (rom_phase),
    .cos_q (rom_q)
  );

  afct_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

endmodule

>>> test/tb_am_fm_cw_tone_generator.sv
// Self-checking testbench for the AM/FM/CW tone generator stream block.
`timescale 1ns / 100ps

module tb_am_fm_cw_tone_generator;
  import afct_pkg::*;

  localparam int PH_W     = PHASE_BITS_DEF;
  localparam int TBL_W    = TABLE_ADDR_BITS_DEF;
  localparam int SAMPLE_W = SAMPLE_FRAC_BITS_DEF + 2;
  localparam int OUT_W    = ((SAMPLE_W + IDX_W + 7) / 8) * 8;
  localparam int QUARTER  = 1 << (TBL_W - 2);

  localparam logic [1:0]           MODE_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam longint S_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint S_MIN = -S_MAX - 1;

  localparam int ITEMS           = 1450;
  localparam int SETTLE_CYCLES   = 14;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int TIMEOUT_NS      = 1_500_000;

  typedef longint unsigned u64_t;
  localparam u64_t HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic [IDX_W-1:0]           index;
    logic                       last;
  } sample_t;

  typedef enum {ROW_CFG, ROW_REQ} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          word;
    bit                   restart;
    bit                   typed;
    sample_t              want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;   // [0] restart
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;  // [16:0] sample, [40:17] sample_index, zero fill
  logic                  out_tlast;

  am_fm_cw_tone_generator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // generator state mirrored by the predictor
  logic [1:0]       mode_reg;
  logic [31:0]      car_step;
  logic [31:0]      base_step;
  logic [IDX_W-1:0] count_reg;
  logic [15:0]      mod_index;
  logic [15:0]      ampl;
  logic [15:0]      freq_dev;
  logic [31:0]      car_acc;
  logic [31:0]      base_acc;
  logic [IDX_W-1:0] rec_count;
  logic [15:0]      cos_rom [0:QUARTER];

  sample_t   pending_samples[$];
  stim_row_t directed_rows[$];

  int  fail_count;
  int  issued;
  int  restarts;
  int  reg_writes;
  int  records;
  int  am_items;
  int  fm_items;
  int  cw_items;
  int  hold_offs;
  bit  tx_quiet;
  bit  rx_quiet;
  bit  hold_off_req;

  always #1 clk = ~clk;

  // floor((v + 2^(s-1)) / 2^s)
  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // quarter-wave cosine table, Q30 Taylor series rounded to Q1.15
  function automatic void build_cos_rom();
    u64_t   x;
    u64_t   x2;
    u64_t   term;
    longint sum;
    for (int k = 0; k <= QUARTER; k++) begin
      x    = (u64_t'(k) * HALF_PI_Q30) >> (TBL_W - 2);
      x2   = (x * x) >> 30;
      term = u64_t'(1) << 30;
      sum  = longint'(term);
      for (int n = 1; n <= 12; n++) begin
        term = ((term * x2) >> 30) / u64_t'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) begin
          sum -= longint'(term);
        end else begin
          sum += longint'(term);
        end
      end
      if (sum < 0) sum = 0;
      sum = (sum + 16384) >>> 15;
      if (sum > UNITY) sum = UNITY;
      cos_rom[k] = 16'(sum);
    end
  endfunction

  function automatic longint cos_q15(logic [31:0] ph);
    logic [TBL_W-1:0] a;
    logic [TBL_W-3:0] off;
    a   = ph[PH_W-1 -: TBL_W];
    off = a[TBL_W-3:0];
    case (a[TBL_W-1 -: 2])
      2'd0:    return longint'(cos_rom[off]);
      2'd1:    return -longint'(cos_rom[QUARTER - off]);
      2'd2:    return -longint'(cos_rom[off]);
      default: return longint'(cos_rom[QUARTER - off]);
    endcase
  endfunction

  // work out the sample that one request produces and advance the record
  task automatic predict_sample(input bit restart, output sample_t res);
    logic [31:0] cph;
    logic [31:0] bph;
    longint      env;
    longint      gain;
    longint      rad;
    longint      shift_ph;
    longint      v;
    longint      s;
    bit          from_one;
    bit          at_end;
    from_one = (mode_reg == MODE_AM) || (mode_reg == MODE_FM);
    if (restart) begin
      rec_count = '0;
      car_acc   = '0;
      base_acc  = '0;
    end
    cph = car_acc + (from_one ? car_step : 32'd0);
    bph = base_acc + (from_one ? base_step : 32'd0);
    case (mode_reg)
      MODE_AM: begin
        env  = UNITY + rnd_shift(longint'(mod_index) * cos_q15(bph), 15);
        gain = rnd_shift(env * longint'(ampl), 15);
        v    = gain * cos_q15(cph);
        am_items++;
      end
      MODE_FM: begin
        // sine is the cosine a quarter turn back
        rad      = longint'(freq_dev) * cos_q15(bph - (32'd1 << (PH_W - 2)));
        shift_ph = rnd_shift(rad * longint'(INV_TWO_PI_Q32), 59 - PH_W);
        v        = cos_q15(cph + shift_ph[31:0]) * UNITY;
        fm_items++;
      end
      default: begin
        v = cos_q15(bph) * UNITY;
        cw_items++;
      end
    endcase
    s = rnd_shift(v, 30 - SAMPLE_FRAC_BITS_DEF);
    if (s > S_MAX) s = S_MAX;
    if (s < S_MIN) s = S_MIN;
    at_end    = (int'(rec_count) + 1) >= int'(count_reg);
    res.value = s[SAMPLE_W-1:0];
    res.index = rec_count + {{(IDX_W-1){1'b0}}, from_one};
    res.last  = at_end;
    if (at_end) begin
      rec_count = '0;
      car_acc   = '0;
      base_acc  = '0;
      records++;
    end else begin
      rec_count = rec_count + 1'b1;
      car_acc   = car_acc + car_step;
      base_acc  = base_acc + base_step;
    end
  endtask

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // hold cfg_we high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] word);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= word;
    @(posedge clk);
    case (idx)
      REG_MODE:      mode_reg  = word[1:0];
      REG_CAR_STEP:  car_step  = word;
      REG_BASE_STEP: base_step = word;
      REG_COUNT:     count_reg = word[IDX_W-1:0];
      REG_MOD_IDX:   mod_index = word[15:0];
      REG_AMPL:      ampl      = word[15:0];
      REG_FREQ_DEV:  freq_dev  = word[15:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic issue_request(input bit restart, input bit typed, input sample_t typed_want);
    sample_t want;
    int      gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, restart};
    do @(posedge clk); while (!in_tready);
    predict_sample(restart, want);
    if (typed) want = typed_want;
    pending_samples.push_back(want);
    issued++;
    if (restart) restarts++;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and wait until every sample is out and the block is idle
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'd0;
    if (r < 20) return 32'hFFFF_FFFF;
    if (r < 60) return $urandom_range(0, 32'h00FF_FFFF);
    return $urandom();
  endfunction

  function automatic logic [15:0] pick_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'd0;
    if (r < 20) return 16'(UNITY);
    if (r < 80) return 16'($urandom_range(0, UNITY));
    return 16'($urandom());
  endfunction

  task automatic random_config();
    logic [31:0] word;
    int          r;
    word      = $urandom();
    word[1:0] = ($urandom_range(0, 99) < 10) ? MODE_SPARE : 2'($urandom_range(0, 2));
    write_reg(REG_MODE, word);
    if ($urandom_range(0, 9) < 7) write_reg(REG_CAR_STEP, pick_step());
    if ($urandom_range(0, 9) < 7) write_reg(REG_BASE_STEP, pick_step());
    if ($urandom_range(0, 9) < 7) begin
      word = $urandom();
      r    = $urandom_range(0, 99);
      // keep records short so that record ends come often
      if (r < 12) begin
        word[IDX_W-1:0] = '0;
      end else if (r < 60) begin
        word[IDX_W-1:0] = IDX_W'($urandom_range(1, 16));
      end else if (r < 85) begin
        word[IDX_W-1:0] = IDX_W'($urandom_range(17, 300));
      end else if (r < 92) begin
        word[IDX_W-1:0] = '1;
      end
      write_reg(REG_COUNT, word);
    end
    if ($urandom_range(0, 9) < 7) begin
      word        = $urandom();
      word[15:0]  = pick_gain();
      write_reg(REG_MOD_IDX, word);
    end
    if ($urandom_range(0, 9) < 7) begin
      word        = $urandom();
      word[15:0]  = pick_gain();
      write_reg(REG_AMPL, word);
    end
    if ($urandom_range(0, 9) < 7) begin
      word = $urandom();
      r    = $urandom_range(0, 9);
      if (r == 0) word[15:0] = 16'd0;
      if (r == 1) word[15:0] = 16'hFFFF;
      write_reg(REG_FREQ_DEV, word);
    end
    if ($urandom_range(0, 19) == 0) write_reg(REG_UNUSED, $urandom());
    cfg_we <= 1'b0;
  endtask

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [31:0] word);
    stim_row_t row;
    row         = '{kind: ROW_CFG, default: '0};
    row.idx     = idx;
    row.word    = word;
    return row;
  endfunction

  function automatic stim_row_t req_row(bit restart);
    stim_row_t row;
    row         = '{kind: ROW_REQ, default: '0};
    row.restart = restart;
    return row;
  endfunction

  function automatic stim_row_t typed_row(bit restart, int value, int index, bit last);
    stim_row_t row;
    row            = req_row(restart);
    row.typed      = 1'b1;
    row.want.value = SAMPLE_W'(value);
    row.want.index = IDX_W'(index);
    row.want.last  = last;
    return row;
  endfunction

  // result checker
  always @(posedge clk) begin
    sample_t got;
    sample_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.value = out_tdata[SAMPLE_W-1:0];
      got.index = out_tdata[SAMPLE_W+IDX_W-1:SAMPLE_W];
      got.last  = out_tlast;
      if (pending_samples.size() == 0) begin
        $error("unexpected sample %0d at index %0d", got.value, got.index);
        fail_count++;
      end else begin
        want = pending_samples.pop_front();
        if (got.value !== want.value) begin
          $error("sample: expected %0d, got %0d", want.value, got.value);
          fail_count++;
        end
        if (got.index !== want.index) begin
          $error("sample_index: expected %0d, got %0d", want.index, got.index);
          fail_count++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, got.last);
          fail_count++;
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        hold_offs++;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        stall_left = pick_gap(rx_quiet);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int  phase;
    int  n;
    bit  cfg_open;
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    fail_count   = 0;
    issued       = 0;
    restarts     = 0;
    reg_writes   = 0;
    records      = 0;
    am_items     = 0;
    fm_items     = 0;
    cw_items     = 0;
    hold_offs    = 0;
    tx_quiet     = 1'b0;
    rx_quiet     = 1'b0;
    hold_off_req = 1'b0;
    mode_reg     = MODE_AM;
    car_step     = '0;
    base_step    = '0;
    count_reg    = IDX_W'(1024);
    mod_index    = 16'd16384;
    ampl         = 16'(UNITY);
    freq_dev     = 16'd4096;
    car_acc      = '0;
    base_acc     = '0;
    rec_count    = '0;
    build_cos_rom();

    // values just after reset, then record ends, mode changes and the odd cases
    directed_rows.push_back(typed_row(1'b0, 49152, 1, 1'b0));
    directed_rows.push_back(typed_row(1'b0, 49152, 2, 1'b0));
    directed_rows.push_back(cfg_row(REG_MODE, 32'(MODE_CW)));
    directed_rows.push_back(typed_row(1'b1, 32768, 0, 1'b0));
    directed_rows.push_back(cfg_row(REG_COUNT, 32'd3));
    directed_rows.push_back(typed_row(1'b0, 32768, 1, 1'b0));
    directed_rows.push_back(typed_row(1'b0, 32768, 2, 1'b1));
    directed_rows.push_back(typed_row(1'b0, 32768, 0, 1'b0));
    // spare mode code runs as CW
    directed_rows.push_back(cfg_row(REG_MODE, 32'hFFFF_FFF0 | 32'(MODE_SPARE)));
    directed_rows.push_back(cfg_row(REG_BASE_STEP, 32'h4000_0000));
    directed_rows.push_back(req_row(1'b1));
    directed_rows.push_back(req_row(1'b0));
    // zero count: every sample closes its record
    directed_rows.push_back(cfg_row(REG_COUNT, 32'd0));
    directed_rows.push_back(req_row(1'b0));
    directed_rows.push_back(req_row(1'b0));
    directed_rows.push_back(cfg_row(REG_COUNT, 32'd100));
    directed_rows.push_back(cfg_row(REG_MODE, 32'(MODE_AM)));
    directed_rows.push_back(cfg_row(REG_CAR_STEP, 32'h0123_4567));
    directed_rows.push_back(cfg_row(REG_BASE_STEP, 32'h0040_0000));
    directed_rows.push_back(req_row(1'b1));
    directed_rows.push_back(req_row(1'b0));
    directed_rows.push_back(req_row(1'b0));
    directed_rows.push_back(req_row(1'b0));
    // count lowered below the counter mid-record
    directed_rows.push_back(cfg_row(REG_COUNT, 32'd2));
    directed_rows.push_back(req_row(1'b0));
    // full-scale AM saturates high
    directed_rows.push_back(cfg_row(REG_BASE_STEP, 32'd0));
    directed_rows.push_back(cfg_row(REG_CAR_STEP, 32'd0));
    directed_rows.push_back(cfg_row(REG_MOD_IDX, 32'(UNITY)));
    directed_rows.push_back(cfg_row(REG_AMPL, 32'(UNITY)));
    directed_rows.push_back(cfg_row(REG_COUNT, 32'hFF00_0400));
    directed_rows.push_back(typed_row(1'b1, 65535, 1, 1'b0));
    // gains beyond 1.0 on a negative carrier saturate low
    directed_rows.push_back(cfg_row(REG_MOD_IDX, 32'hABCD_FFFF));
    directed_rows.push_back(cfg_row(REG_AMPL, 32'h1234_FFFF));
    directed_rows.push_back(cfg_row(REG_CAR_STEP, 32'h8000_0000));
    directed_rows.push_back(typed_row(1'b1, -65536, 1, 1'b0));
    directed_rows.push_back(cfg_row(REG_AMPL, 32'd0));
    directed_rows.push_back(cfg_row(REG_MOD_IDX, 32'd0));
    directed_rows.push_back(typed_row(1'b0, 0, 2, 1'b0));
    directed_rows.push_back(cfg_row(REG_MODE, 32'(MODE_FM)));
    directed_rows.push_back(cfg_row(REG_FREQ_DEV, 32'h0000_FFFF));
    directed_rows.push_back(cfg_row(REG_CAR_STEP, 32'h1234_5678));
    directed_rows.push_back(cfg_row(REG_BASE_STEP, 32'h0ABC_DEF0));
    directed_rows.push_back(req_row(1'b1));
    directed_rows.push_back(req_row(1'b0));
    directed_rows.push_back(req_row(1'b0));
    directed_rows.push_back(cfg_row(REG_FREQ_DEV, 32'd0));
    directed_rows.push_back(req_row(1'b0));
    // new step mid-record: accumulators carry on from where they are
    directed_rows.push_back(cfg_row(REG_CAR_STEP, 32'hFFFF_FFFF));
    directed_rows.push_back(req_row(1'b0));
    directed_rows.push_back(cfg_row(REG_COUNT, 32'h00FF_FFFF));
    directed_rows.push_back(cfg_row(REG_UNUSED, 32'hFFFF_FFFF));
    directed_rows.push_back(req_row(1'b0));
    directed_rows.push_back(req_row(1'b1));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_open = 1'b0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        if (!cfg_open) begin
          settle();
          cfg_open = 1'b1;
        end
        write_reg(directed_rows[i].idx, directed_rows[i].word);
      end else begin
        if (cfg_open) begin
          cfg_we   <= 1'b0;
          cfg_open = 1'b0;
        end
        issue_request(directed_rows[i].restart, directed_rows[i].typed,
                      directed_rows[i].want);
      end
    end

    phase = 0;
    while (issued < ITEMS) begin
      settle();
      random_config();
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      n = $urandom_range(10, 60);
      // one long receiver hold-off while requests keep coming
      if (phase == 2) begin
        hold_off_req = 1'b1;
        n            = 80;
      end
      repeat (n) issue_request($urandom_range(0, 99) < 6, 1'b0, '0);
      phase++;
    end

    in_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d samples (AM %0d, FM %0d, CW %0d) over %0d settings.",
             issued, am_items, fm_items, cw_items, phase + 1);
    $display("It saw %0d record ends, %0d restarts, %0d register writes, %0d long hold-offs.",
             records, restarts, reg_writes, hold_offs);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
